/* src/rsc_pkg.sv */
// Shared types and constants for the rotor substitution cipher.
package rsc_pkg;

   localparam int unsigned LETTERS = 26;

   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_GAP   = 8'd32;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_LF      = 8'h0A;

   localparam logic [4:0] LAST_POS   = 5'd25;

   localparam logic [2:0] CSR_DECRYPT_MODE  = 3'd0;
   localparam logic [2:0] CSR_DROP_SPACES   = 3'd1;
   localparam logic [2:0] CSR_KEY_PART_LOW  = 3'd2;
   localparam logic [2:0] CSR_KEY_PART_MID  = 3'd3;
   localparam logic [2:0] CSR_KEY_PART_HIGH = 3'd4;

   localparam logic [1:0] KIND_LF     = 2'd0;
   localparam logic [1:0] KIND_SPACE  = 2'd1;
   localparam logic [1:0] KIND_LETTER = 2'd2;

   typedef logic [LETTERS-1:0][4:0] key_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [4:0] letter;
      logic [4:0] pos;
      logic [4:0] idx;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

/* src/rsc_front.sv */
// Front end: classifies input bytes, tracks the rotor and emits work entries.
module rsc_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic [7:0]                 in_byte,
   input  logic                       drop_spaces,
   output logic                       push,
   output rsc_pkg::entry_type         entry
);

   logic [4:0] rotor_ff;
   logic [4:0] rotor_in;
   logic [7:0] folded;
   logic [7:0] offset;
   logic [5:0] sum;
   logic       emit;
   logic       advance;

   always_comb begin
      folded = in_byte;
      if (in_byte >= rsc_pkg::CH_UPPER_A && in_byte <= rsc_pkg::CH_UPPER_Z) begin
         folded = in_byte + rsc_pkg::CASE_GAP;
      end
      offset = folded - rsc_pkg::CH_LOWER_A;
      sum    = {1'b0, offset[4:0]} + {1'b0, rotor_ff};
      if (sum >= 6'(rsc_pkg::LETTERS)) begin
         sum = sum - 6'(rsc_pkg::LETTERS);
      end

      entry.letter = offset[4:0];
      entry.pos    = rotor_ff;
      entry.idx    = sum[4:0];
      entry.kind   = rsc_pkg::KIND_LETTER;
      emit         = 1'b0;
      advance      = 1'b0;

      if (in_byte == rsc_pkg::CH_LF) begin
         entry.kind = rsc_pkg::KIND_LF;
         emit       = 1'b1;
      end else if (in_byte == rsc_pkg::CH_SPACE) begin
         entry.kind = rsc_pkg::KIND_SPACE;
         emit       = !drop_spaces;
         advance    = !drop_spaces;
      end else if (folded >= rsc_pkg::CH_LOWER_A && folded <= rsc_pkg::CH_LOWER_Z) begin
         emit    = 1'b1;
         advance = 1'b1;
      end
   end

   assign push = accept && emit;

   always_comb begin
      rotor_in = rotor_ff;
      if (accept && advance) begin
         rotor_in = (rotor_ff == rsc_pkg::LAST_POS) ? 5'd0 : rotor_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rotor_ff <= 5'd0;
      end else begin
         rotor_ff <= rotor_in;
      end
   end

endmodule

/* src/rsc_queue.sv */
// Two-entry queue between the front end and the lookup stage.
module rsc_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  rsc_pkg::entry_type         push_entry,
   input  logic                       pop,
   output rsc_pkg::entry_type         head,
   output rsc_pkg::queue_status_type  status
);

   rsc_pkg::entry_type entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);
   assign head         = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* src/rsc_back.sv */
// Back end: key lookup or inverse search, and the registered result stage.
module rsc_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       head_valid,
   input  rsc_pkg::entry_type         head,
   input  rsc_pkg::key_type           key,
   input  logic                       decrypt_mode,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [7:0]                 rsp_out_byte
);

   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic [7:0]                 rsp_out_byte_ff;
   logic [7:0]                 rsp_out_byte_in;
   logic [rsc_pkg::LETTERS-1:0]   match;
   logic [2*rsc_pkg::LETTERS-1:0] doubled;
   logic [2*rsc_pkg::LETTERS-1:0] shifted;
   logic [rsc_pkg::LETTERS-1:0]   rotated;
   logic [4:0]                 distance;
   logic                       found;
   logic                       has_result;
   logic [7:0]                 result;

   always_comb begin
      for (int m = 0; m < rsc_pkg::LETTERS; m++) begin
         match[m] = (key[m] == head.letter);
      end
      doubled  = {match, match};
      shifted  = doubled >> head.pos;
      rotated  = shifted[rsc_pkg::LETTERS-1:0];
      found    = |rotated;
      distance = 5'd0;
      for (int j = rsc_pkg::LETTERS - 1; j >= 0; j--) begin
         if (rotated[j]) begin
            distance = 5'(j);
         end
      end
   end

   always_comb begin
      has_result = 1'b1;
      result     = rsc_pkg::CH_LF;
      case (head.kind)
         rsc_pkg::KIND_LF: begin
            result = rsc_pkg::CH_LF;
         end
         rsc_pkg::KIND_SPACE: begin
            result = rsc_pkg::CH_SPACE;
         end
         rsc_pkg::KIND_LETTER: begin
            if (decrypt_mode) begin
               result     = rsc_pkg::CH_LOWER_A + {3'b000, distance};
               has_result = found;
            end else begin
               result = rsc_pkg::CH_LOWER_A + {3'b000, key[head.idx]};
            end
         end
         default: begin
            has_result = 1'b0;
         end
      endcase
   end

   assign pop = head_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_out_byte_in = rsp_out_byte_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (pop && has_result) begin
         rsp_valid_in    = 1'b1;
         rsp_out_byte_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_out_byte_ff <= rsp_out_byte_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_out_byte_ff;

endmodule

/* src/rotor_substitution_cipher.sv */
// Top level of the single-rotor substitution cipher.
//
// Usage:
//   req_ channel takes one raw ASCII byte per transaction (req_in_byte).
//   rsp_ channel returns at most one byte per input: a lower-case letter,
//   a space or a line feed (rsp_out_byte). Dropped bytes give nothing.
//   csr_ channel writes one register per transaction: index 0 decrypt_mode,
//   1 drop_spaces, 2..4 the key parts; other indexes are ignored. csr_ready
//   is always high. Write only while no transaction is in flight.
// Timing:
//   One byte per cycle sustained while rsp_ready stays high. An accepted
//   input is written into the two-entry queue; the lookup then runs on the
//   queue head and fills the output register that drives rsp_valid.
// Reset:
//   Clears the rotor, the queue pointers and count, the output valid and the CSRs to 0.
// Stall:
//   The output register holds while rsp_ready is low; the queue then fills
//   and req_ready drops after two further queued transactions. Once the
//   queue pops from full, req_ready returns on the following cycle.
module rotor_substitution_cipher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [59:0] csr_data
);

   logic        decrypt_mode_ff;
   logic        drop_spaces_ff;
   logic [59:0] key_low_ff;
   logic [59:0] key_mid_ff;
   logic [9:0]  key_high_ff;
   logic        csr_write;

   rsc_pkg::key_type          key;
   rsc_pkg::entry_type        front_entry;
   rsc_pkg::entry_type        head;
   rsc_pkg::queue_status_type queue_status;
   logic                      accept;
   logic                      push;
   logic                      pop;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         decrypt_mode_ff <= 1'b0;
         drop_spaces_ff  <= 1'b0;
         key_low_ff      <= 60'd0;
         key_mid_ff      <= 60'd0;
         key_high_ff     <= 10'd0;
      end else if (csr_write) begin
         unique case (csr_index)
            rsc_pkg::CSR_DECRYPT_MODE:  decrypt_mode_ff <= csr_data[0];
            rsc_pkg::CSR_DROP_SPACES:   drop_spaces_ff  <= csr_data[0];
            rsc_pkg::CSR_KEY_PART_LOW:  key_low_ff      <= csr_data;
            rsc_pkg::CSR_KEY_PART_MID:  key_mid_ff      <= csr_data;
            rsc_pkg::CSR_KEY_PART_HIGH: key_high_ff     <= csr_data[9:0];
            default: begin
            end
         endcase
      end
   end

   assign key = {key_high_ff, key_mid_ff, key_low_ff};

   assign req_ready = !queue_status.full;
   assign accept    = req_valid && req_ready;

   rsc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .in_byte     (req_in_byte),
      .drop_spaces (drop_spaces_ff),
      .push        (push),
      .entry       (front_entry)
   );

   rsc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (front_entry),
      .pop        (pop),
      .head       (head),
      .status     (queue_status)
   );

   rsc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (!queue_status.empty),
      .head         (head),
      .key          (key),
      .decrypt_mode (decrypt_mode_ff),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte)
   );

endmodule
